// File: hw/rtl/epoch_seconds_to_civil_datetime_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the epoch to civil date/time converter
// Shared concurrent check forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CIVIL_DATETIME_DEFINES_SVH
`define EPOCH_SECONDS_TO_CIVIL_DATETIME_DEFINES_SVH

// Same-cycle implication.
`define ECD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ECD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/ecd_pkg.sv
// ----------------------------------------------------------------------------
// ecd_pkg
// Widths, calendar constants, reciprocals and shared types of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ecd_pkg;

	// field widths
	localparam int EpochW = 39;
	localparam int YearW  = 15;
	localparam int MonthW = 4;
	localparam int DomW   = 5;
	localparam int HourW  = 5;
	localparam int MinW   = 6;
	localparam int SecW   = 6;

	// internal widths
	localparam int JdnW  = 23;
	localparam int SodW  = 17;
	localparam int AW    = 23;
	localparam int BW    = 8;
	localparam int CW    = 18;
	localparam int DW    = 10;
	localparam int EW    = 9;
	localparam int MW    = 4;
	localparam int RemW  = 11;
	localparam int RhW   = 12;

	localparam int NumStages = 12;

	// supported span: JDN 0 midnight through the last second of year 9999
	localparam logic signed [EpochW-1:0] SpanLow  = -39'sd210866803200;
	localparam logic signed [EpochW-1:0] SpanHigh = 39'sd253402300799;

	// 86400 = 128 * 675: low bits peel off, the rest divides by 675
	localparam int SecLoW    = 7;
	localparam int DayHi     = 675;
	localparam int RecipDayK = 32;
	localparam logic [JdnW-1:0] RecipDay = JdnW'((64'd1 << RecipDayK) / 64'd675);

	// calendar constants
	localparam int JdnShift   = 32044;
	localparam int CycleDays  = 146097;
	localparam int QuadDays   = 1461;
	localparam int MonthSpan  = 153;
	localparam int YearBase   = 4800;
	localparam int MonthWrap  = 10;
	localparam int SecPerHour = 3600;
	localparam int SecPerMin  = 60;

	// exact reciprocals: ceil(2^k / d) with k = input bits + ceil(log2 d)
	localparam int RecipBK = 43;
	localparam logic [25:0] RecipB =
		26'(((64'd1 << RecipBK) + 64'd146097 - 64'd1) / 64'd146097);
	localparam int RecipDK = 31;
	localparam logic [20:0] RecipD =
		21'(((64'd1 << RecipDK) + 64'd1461 - 64'd1) / 64'd1461);
	localparam int RecipMK = 19;
	localparam logic [11:0] RecipM =
		12'(((64'd1 << RecipMK) + 64'd153 - 64'd1) / 64'd153);
	localparam int RecipHourK = 29;
	localparam logic [17:0] RecipHour =
		18'(((64'd1 << RecipHourK) + 64'd3600 - 64'd1) / 64'd3600);
	localparam int RecipMinK = 18;
	localparam logic [12:0] RecipMin =
		13'(((64'd1 << RecipMinK) + 64'd60 - 64'd1) / 64'd60);

	typedef logic signed [EpochW-1:0] epoch_t;

	typedef struct packed {
		logic            oor;
		logic [JdnW-1:0] jdn;
		logic [SodW-1:0] sod;
	} day_split_t;

	typedef struct packed {
		logic [HourW-1:0] hour;
		logic [MinW-1:0]  minute;
		logic [SecW-1:0]  second;
	} tod_t;

	typedef struct packed {
		logic signed [YearW-1:0] year;
		logic [MonthW-1:0]       month;
		logic [DomW-1:0]         day_of_month;
	} date_t;

	// days from March 1 to the first of the month, month index from March
	function automatic logic [EW-1:0] days_before_month(input logic [MW-1:0] m);
		logic [EW-1:0] r;
		unique case (m)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ecd_in_if.sv
// ----------------------------------------------------------------------------
// ecd_in_if
// Input stream: one signed epoch second count per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecd_in_if;
	import ecd_pkg::*;

	logic   valid;
	logic   ready;
	epoch_t epoch_seconds;

	modport source (output valid, output epoch_seconds, input ready);
	modport sink   (input valid, input epoch_seconds, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ecd_out_if.sv
// ----------------------------------------------------------------------------
// ecd_out_if
// Output stream: one civil date and time of day per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecd_out_if;
	import ecd_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [YearW-1:0] year;
	logic [MonthW-1:0]       month;
	logic [DomW-1:0]         day_of_month;
	logic [HourW-1:0]        hour;
	logic [MinW-1:0]         minute;
	logic [SecW-1:0]         second;
	logic                    out_of_range;

	modport source (output valid, output year, output month, output day_of_month,
		output hour, output minute, output second, output out_of_range, input ready);
	modport sink (input valid, input year, input month, input day_of_month,
		input hour, input minute, input second, input out_of_range, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ecd_day_split.sv
// ----------------------------------------------------------------------------
// ecd_day_split
// Stages 1-5: range check, rebase to JDN 0, floor split into day and second.
// ----------------------------------------------------------------------------
`default_nettype none

module ecd_day_split (
	input  logic               clk,
	input  logic               adv,
	input  ecd_pkg::epoch_t    epoch_seconds,
	output ecd_pkg::day_split_t split
);
	import ecd_pkg::*;

	localparam int XW = EpochW - SecLoW;

	epoch_t              t_s1;
	logic [EpochW-1:0]   u_s2;
	logic                oor_s2, oor_s3, oor_s4;
	logic [XW-1:0]       x_s3;
	logic [JdnW-1:0]     q0_s3, q0_s4;
	logic [SecLoW-1:0]   lo_s3, lo_s4;
	logic [RemW-1:0]     r0_s4;
	day_split_t          split_s5;

	logic                oor;
	logic [EpochW-1:0]   u;
	logic [XW-1:0]       x;
	logic [XW+JdnW-1:0]  pq;
	logic [XW-1:0]       qm;
	logic [XW-1:0]       rf;
	logic                fix;
	logic [RemW-1:0]     r;

	assign oor = (t_s1 < SpanLow) || (t_s1 > SpanHigh);
	// seconds since JDN 0 midnight, never negative inside the span
	assign u   = EpochW'(t_s1 - SpanLow);

	assign x  = u_s2[EpochW-1:SecLoW];
	assign pq = (XW+JdnW)'(x) * (XW+JdnW)'(RecipDay);

	assign qm = XW'(q0_s3) * XW'(DayHi);
	assign rf = x_s3 - qm;

	// estimate is at most one low: correct once
	assign fix = r0_s4 >= RemW'(DayHi);
	assign r   = fix ? r0_s4 - RemW'(DayHi) : r0_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1   <= epoch_seconds;
			u_s2   <= u;
			oor_s2 <= oor;
			x_s3   <= x;
			q0_s3  <= pq[RecipDayK +: JdnW];
			lo_s3  <= u_s2[SecLoW-1:0];
			oor_s3 <= oor_s2;
			r0_s4  <= rf[RemW-1:0];
			q0_s4  <= q0_s3;
			lo_s4  <= lo_s3;
			oor_s4 <= oor_s3;
			split_s5.oor <= oor_s4;
			split_s5.jdn <= q0_s4 + JdnW'(fix);
			split_s5.sod <= {r[SodW-SecLoW-1:0], lo_s4};
		end
	end

	assign split = split_s5;

endmodule

`default_nettype wire

// File: hw/rtl/ecd_tod.sv
// ----------------------------------------------------------------------------
// ecd_tod
// Stages 6-12: second of day to hour, minute and second.
// ----------------------------------------------------------------------------
`default_nettype none

module ecd_tod (
	input  logic                  clk,
	input  logic                  adv,
	input  logic [ecd_pkg::SodW-1:0] sod,
	input  logic                  clr,
	output ecd_pkg::tod_t         tod
);
	import ecd_pkg::*;

	localparam int PhW  = SodW + 18;
	localparam int PmnW = RhW + 13;

	logic [SodW-1:0]  sod_s6;
	logic [HourW-1:0] hour_s6, hour_s7, hour_s8;
	logic [RhW-1:0]   rh_s7, rh_s8;
	logic [MinW-1:0]  min_s8;
	tod_t             tod_s9, tod_s10, tod_s11, tod_s12;

	logic [PhW-1:0]   ph;
	logic [SodW-1:0]  hq;
	logic [SodW-1:0]  rh_full;
	logic [PmnW-1:0]  pmn;
	logic [RhW-1:0]   mq;
	logic [RhW-1:0]   sec_full;

	assign ph       = PhW'(sod) * PhW'(RecipHour);
	assign hq       = SodW'(hour_s6) * SodW'(SecPerHour);
	assign rh_full  = sod_s6 - hq;
	assign pmn      = PmnW'(rh_s7) * PmnW'(RecipMin);
	assign mq       = RhW'(min_s8) * RhW'(SecPerMin);
	assign sec_full = rh_s8 - mq;

	always_ff @(posedge clk) begin
		if (adv) begin
			hour_s6        <= ph[RecipHourK +: HourW];
			sod_s6         <= sod;
			rh_s7          <= rh_full[RhW-1:0];
			hour_s7        <= hour_s6;
			min_s8         <= pmn[RecipMinK +: MinW];
			rh_s8          <= rh_s7;
			hour_s8        <= hour_s7;
			tod_s9.hour    <= hour_s8;
			tod_s9.minute  <= min_s8;
			tod_s9.second  <= sec_full[SecW-1:0];
			tod_s10        <= tod_s9;
			tod_s11        <= tod_s10;
			// zero the fields of an out-of-span beat
			tod_s12        <= clr ? '0 : tod_s11;
		end
	end

	assign tod = tod_s12;

endmodule

`default_nettype wire

// File: hw/rtl/ecd_civil.sv
// ----------------------------------------------------------------------------
// ecd_civil
// Stages 6-12: Julian day number to proleptic Gregorian year, month, day.
// ----------------------------------------------------------------------------
`default_nettype none

module ecd_civil (
	input  logic                     clk,
	input  logic                     adv,
	input  logic [ecd_pkg::JdnW-1:0] jdn,
	input  logic                     clr,
	output ecd_pkg::date_t           date
);
	import ecd_pkg::*;

	localparam int NaW  = AW + 2;
	localparam int PbW  = NaW + 26;
	localparam int NcW  = CW + 2;
	localparam int PdW  = NcW + 21;
	localparam int NeW  = EW + 2;
	localparam int PmW  = NeW + 12;
	localparam int DqW  = 21;
	localparam int YrW  = YearW + 1;

	logic [AW-1:0]  a_s6, a_s7;
	logic [BW-1:0]  b_s7, b_s8, b_s9, b_s10, b_s11;
	logic [CW-1:0]  c_s8, c_s9;
	logic [DW-1:0]  d_s9, d_s10, d_s11;
	logic [EW-1:0]  e_s10, e_s11;
	logic [MW-1:0]  m_s11;
	date_t          date_s12;

	logic [NaW-1:0] na;
	logic [PbW-1:0] pb;
	logic [NaW-1:0] bq;
	logic [NaW-1:0] c_full;
	logic [NcW-1:0] nc;
	logic [PdW-1:0] pd;
	logic [DqW-1:0] dq;
	logic [DqW-1:0] e_full;
	logic [NeW-1:0] ne;
	logic [PmW-1:0] pm;
	logic           wrap;
	logic [EW-1:0]  dom_full;
	logic [MonthW-1:0] mon;
	logic [YrW-1:0] yr;

	// 4a + 3 and 4c + 3 are shifts with the low bits set
	assign na     = {a_s6, 2'b11};
	assign pb     = PbW'(na) * PbW'(RecipB);
	assign bq     = NaW'(b_s7) * NaW'(CycleDays);
	assign c_full = NaW'(a_s7) - (bq >> 2);
	assign nc     = {c_s8, 2'b11};
	assign pd     = PdW'(nc) * PdW'(RecipD);
	assign dq     = DqW'(d_s9) * DqW'(QuadDays);
	assign e_full = DqW'(c_s9) - (dq >> 2);
	assign ne     = NeW'({e_s10, 2'b00}) + NeW'(e_s10) + NeW'(2);
	assign pm     = PmW'(ne) * PmW'(RecipM);

	// month index counts from March; January and February roll into next year
	assign wrap     = m_s11 >= MW'(MonthWrap);
	assign dom_full = e_s11 - days_before_month(m_s11) + EW'(1);
	assign mon      = wrap ? m_s11 - MW'(MonthWrap - 1) : m_s11 + MW'(3);
	assign yr       = YrW'(b_s11) * YrW'(100) + YrW'(d_s11) - YrW'(YearBase) + YrW'(wrap);

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s6  <= jdn + AW'(JdnShift);
			b_s7  <= pb[RecipBK +: BW];
			a_s7  <= a_s6;
			c_s8  <= c_full[CW-1:0];
			b_s8  <= b_s7;
			d_s9  <= pd[RecipDK +: DW];
			c_s9  <= c_s8;
			b_s9  <= b_s8;
			e_s10 <= e_full[EW-1:0];
			d_s10 <= d_s9;
			b_s10 <= b_s9;
			m_s11 <= pm[RecipMK +: MW];
			e_s11 <= e_s10;
			d_s11 <= d_s10;
			b_s11 <= b_s10;
			if (clr) begin
				date_s12 <= '0;
			end else begin
				date_s12.year         <= signed'(yr[YearW-1:0]);
				date_s12.month        <= mon;
				date_s12.day_of_month <= dom_full[DomW-1:0];
			end
		end
	end

	assign date = date_s12;

endmodule

`default_nettype wire

// File: hw/rtl/epoch_seconds_to_civil_datetime.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_civil_datetime
// Signed epoch seconds to proleptic Gregorian date and time of day.
// ----------------------------------------------------------------------------
// Usage:
//   epoch    : sink stream, one signed 39-bit count of seconds since
//              1970-01-01 00:00:00 UTC per beat.
//   datetime : source stream, one year/month/day/hour/minute/second result
//              per input beat, in order, plus out_of_range.
//   The datapath is a 12-register pipeline; each multiply by a reciprocal
//   sits between its own pair of registers. A result appears on datetime
//   once its input beat has passed all twelve registers, and one beat per
//   cycle is sustained for back-to-back inputs while datetime does not stall.
//   Inputs before JDN 0 or after 9999-12-31 23:59:59 return out_of_range
//   high with all other fields zero.
//   When datetime stalls, the whole pipeline holds and epoch.ready drops in
//   the same cycle; nothing is lost or repeated.
//   Reset clears the stage valid bits only: the pipeline comes up empty and
//   ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "epoch_seconds_to_civil_datetime_defines.svh"

module epoch_seconds_to_civil_datetime (
	input  logic             clk,
	input  logic             arst_n,
	ecd_in_if.sink           epoch,
	ecd_out_if.source        datetime
);
	import ecd_pkg::*;

	logic                 adv;
	logic [NumStages-1:0] vld_q;
	logic                 oor_s6, oor_s7, oor_s8, oor_s9, oor_s10, oor_s11;
	day_split_t           split;
	tod_t                 tod;
	date_t                date;

	// whole pipeline moves when the output slot is free or being drained
	assign adv         = !vld_q[NumStages-1] || datetime.ready;
	assign epoch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NumStages-2:0], epoch.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s6  <= split.oor;
			oor_s7  <= oor_s6;
			oor_s8  <= oor_s7;
			oor_s9  <= oor_s8;
			oor_s10 <= oor_s9;
			oor_s11 <= oor_s10;
		end
	end

	ecd_day_split u_split (
		.clk           (clk),
		.adv           (adv),
		.epoch_seconds (epoch.epoch_seconds),
		.split         (split)
	);

	ecd_tod u_tod (
		.clk (clk),
		.adv (adv),
		.sod (split.sod),
		.clr (oor_s11),
		.tod (tod)
	);

	ecd_civil u_civil (
		.clk  (clk),
		.adv  (adv),
		.jdn  (split.jdn),
		.clr  (oor_s11),
		.date (date)
	);

	logic oor_s12;

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s12 <= oor_s11;
		end
	end

	assign datetime.valid        = vld_q[NumStages-1];
	assign datetime.year         = date.year;
	assign datetime.month        = date.month;
	assign datetime.day_of_month = date.day_of_month;
	assign datetime.hour         = tod.hour;
	assign datetime.minute       = tod.minute;
	assign datetime.second       = tod.second;
	assign datetime.out_of_range = oor_s12;

	`ECD_ASSERT_NXT(a_stall_holds, clk, arst_n, datetime.valid && !datetime.ready, $stable(vld_q), "pipeline moved under stall")
	`ECD_ASSERT_IMP(a_empty_ready, clk, arst_n, !datetime.valid, epoch.ready, "empty output slot but not ready")
	`ECD_ASSERT_IMP(a_oor_zero, clk, arst_n, datetime.valid && datetime.out_of_range, datetime.year == 0 && datetime.month == 0 && datetime.day_of_month == 0 && datetime.hour == 0 && datetime.minute == 0 && datetime.second == 0, "out-of-span beat has nonzero fields")
	`ECD_ASSERT_IMP(a_fields_legal, clk, arst_n, datetime.valid && !datetime.out_of_range, datetime.month >= 1 && datetime.month <= 12 && datetime.day_of_month >= 1 && datetime.hour <= 23 && datetime.minute <= 59 && datetime.second <= 59, "date or time field out of its range")

endmodule

`default_nettype wire

// File: tb/sv/epoch_seconds_to_civil_datetime_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_civil_datetime_test
// Streams signed epoch second counts into the converter and checks every
// date/time beat against an in-bench calendar predictor. Both streams idle
// and stall at random. The run also covers span edges, day borrows, leap
// days and raw 39-bit noise.
// ----------------------------------------------------------------------------

module epoch_seconds_to_civil_datetime_test;
	import ecd_pkg::*;

	typedef struct packed {
		logic signed [YearW-1:0] year;
		logic [MonthW-1:0]       month;
		logic [DomW-1:0]         day_of_month;
		logic [HourW-1:0]        hour;
		logic [MinW-1:0]         minute;
		logic [SecW-1:0]         second;
		logic                    out_of_range;
	} civil_t;

	typedef struct {
		epoch_t epoch;
		civil_t want;
	} civil_due_t;

	// drain marks a point where the sender waits for all results
	typedef struct {
		bit     drain;
		epoch_t value;
	} epoch_req_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	localparam longint SpanLo64   = SpanLow;
	localparam longint SpanHi64   = SpanHigh;
	localparam longint SpanCount  = SpanHi64 - SpanLo64 + 1;
	localparam longint SecsPerDay = 86400;
	localparam longint DayCount   = SpanCount / SecsPerDay;
	localparam longint JdnEpoch   = 2440588;
	localparam int     RandomBeats = 1150;

	logic clk;
	logic arst_n;

	ecd_in_if  epoch_bus();
	ecd_out_if civil_bus();

	epoch_seconds_to_civil_datetime i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.epoch    (epoch_bus),
		.datetime (civil_bus)
	);

	epoch_req_t epoch_backlog[$];
	civil_due_t civil_due[$];

	int errors;
	int accepted;
	int received;
	int oor_seen;
	int leap_days_seen;
	int pre_epoch_seen;

	// sender state
	epoch_req_t head_req;
	int         burst_left;
	int         gap_left;
	civil_due_t sent_due;

	// receiver state
	rx_mode_t   rx_mode;
	int         mode_left;
	int         hold_left;
	int         rx_cycle;
	civil_due_t got_due;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// calendar conversion with floor split and integer Gregorian arithmetic
	function automatic civil_t civil_of_epoch(input epoch_t t);
		civil_t r;
		longint secs, days, sod, jdn, a, b, c, d, e, m, yr, mo, dom;
		r = '0;
		secs = t;
		if (secs < SpanLo64 || secs > SpanHi64) begin
			r.out_of_range = 1'b1;
			return r;
		end
		days = secs / SecsPerDay;
		sod  = secs % SecsPerDay;
		if (sod < 0) begin
			sod  = sod + SecsPerDay;
			days = days - 1;
		end
		jdn = days + JdnEpoch;
		a   = jdn + 32044;
		b   = (4 * a + 3) / 146097;
		c   = a - (b * 146097) / 4;
		d   = (4 * c + 3) / 1461;
		e   = c - (1461 * d) / 4;
		m   = (5 * e + 2) / 153;
		dom = e - (153 * m + 2) / 5 + 1;
		mo  = m + 3 - 12 * (m / 10);
		yr  = b * 100 + d - 4800 + m / 10;
		r.year         = yr[YearW-1:0];
		r.month        = mo[MonthW-1:0];
		r.day_of_month = dom[DomW-1:0];
		r.hour         = HourW'(sod / 3600);
		r.minute       = MinW'((sod / 60) % 60);
		r.second       = SecW'(sod % 60);
		return r;
	endfunction

	function automatic epoch_t random_epoch();
		longint unsigned r;
		longint v;
		int pick;
		r = {$urandom(), $urandom()};
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			v = SpanLo64 + longint'(r % SpanCount);
		end else if (pick < 78) begin
			// land on midnight, on the second before the next midnight, or on any second of a random day
			v = SpanLo64 + longint'(r % DayCount) * SecsPerDay;
			case ($urandom_range(0, 2))
				0: v = v + SecsPerDay - 1;
				1: v = v + $urandom_range(0, 86399);
				default: ;
			endcase
		end else if (pick < 88) begin
			if ($urandom_range(0, 1))
				v = SpanLo64 - 200 + $urandom_range(0, 400);
			else
				v = SpanHi64 - 200 + $urandom_range(0, 400);
		end else begin
			v = longint'(r[EpochW-1:0]) - (longint'(r[EpochW-1]) << EpochW);
		end
		return epoch_t'(v);
	endfunction

	task automatic add_epoch(input longint v);
		epoch_req_t q;
		q.drain = 1'b0;
		q.value = epoch_t'(v);
		epoch_backlog.push_back(q);
	endtask

	task automatic add_drain();
		epoch_req_t q;
		q.drain = 1'b1;
		q.value = '0;
		epoch_backlog.push_back(q);
	endtask

	task automatic check_field(input string name, input epoch_t t,
			input logic signed [15:0] want, input logic signed [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t mismatch %s for epoch %0d: expected %0d, actual %0d",
				$time, name, t, want, got);
		end
	endtask

	// driver: bursts of random length with random gaps, drain points honored
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_bus.valid         <= 1'b0;
			epoch_bus.epoch_seconds <= '0;
			burst_left = 1;
			gap_left   = 0;
		end else begin
			if (epoch_bus.valid && epoch_bus.ready) begin
				sent_due.epoch = epoch_bus.epoch_seconds;
				sent_due.want  = civil_of_epoch(epoch_bus.epoch_seconds);
				civil_due.push_back(sent_due);
				accepted++;
			end
			if (!epoch_bus.valid || epoch_bus.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					epoch_bus.valid <= 1'b0;
				end else if (epoch_backlog.size() == 0) begin
					epoch_bus.valid <= 1'b0;
				end else if (epoch_backlog[0].drain) begin
					epoch_bus.valid <= 1'b0;
					if (civil_due.size() == 0)
						void'(epoch_backlog.pop_front());
				end else begin
					head_req = epoch_backlog.pop_front();
					epoch_bus.valid         <= 1'b1;
					epoch_bus.epoch_seconds <= head_req.value;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 30);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// monitor: checks each result beat and stalls on its own pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			civil_bus.ready <= 1'b0;
			rx_mode   = RX_OPEN;
			mode_left = 0;
			hold_left = 0;
			rx_cycle  = 0;
		end else begin
			rx_cycle++;
			if (civil_bus.valid && civil_bus.ready) begin
				received++;
				if (civil_due.size() == 0) begin
					errors++;
					$display("%0t unexpected result beat: expected none, actual year %0d oor %0b",
						$time, civil_bus.year, civil_bus.out_of_range);
				end else begin
					got_due = civil_due.pop_front();
					check_field("year", got_due.epoch, got_due.want.year, civil_bus.year);
					check_field("month", got_due.epoch, got_due.want.month, civil_bus.month);
					check_field("day_of_month", got_due.epoch, got_due.want.day_of_month,
						civil_bus.day_of_month);
					check_field("hour", got_due.epoch, got_due.want.hour, civil_bus.hour);
					check_field("minute", got_due.epoch, got_due.want.minute, civil_bus.minute);
					check_field("second", got_due.epoch, got_due.want.second, civil_bus.second);
					check_field("out_of_range", got_due.epoch, got_due.want.out_of_range,
						civil_bus.out_of_range);
					if (got_due.want.out_of_range)
						oor_seen++;
					else if (got_due.epoch < 0)
						pre_epoch_seen++;
					if (!got_due.want.out_of_range && got_due.want.month == 2 &&
							got_due.want.day_of_month == 29)
						leap_days_seen++;
				end
				// hold off long enough to fill the pipeline and back up the input
				if (received == 400)
					hold_left = 80;
			end
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 120);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				civil_bus.ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN:     civil_bus.ready <= 1'b1;
					RX_COIN:     civil_bus.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE:   civil_bus.ready <= ($urandom_range(0, 3) == 0);
					RX_PERIODIC: civil_bus.ready <= (rx_cycle % 5 != 0);
					default:     civil_bus.ready <= 1'b1;
				endcase
			end
		end
	end

	initial begin
		#3_000_000;
		$display("FAIL epoch_seconds_to_civil_datetime");
		$finish;
	end

	initial begin
		arst_n = 1'b0;

		// span edges, raw extremes, day borrows, leap days, calendar switch
		add_epoch(SpanLo64);
		add_epoch(SpanLo64 - 1);
		add_epoch(SpanHi64);
		add_epoch(SpanHi64 + 1);
		add_epoch(-(longint'(1) << (EpochW - 1)));
		add_epoch((longint'(1) << (EpochW - 1)) - 1);
		add_epoch(0);
		add_epoch(-1);
		add_epoch(1);
		add_epoch(86399);
		add_epoch(86400);
		add_epoch(-86400);
		add_epoch(-86401);
		add_epoch(951868799);
		add_epoch(951868800);
		add_epoch(-2203891201);
		add_epoch(946684799);
		add_epoch(2147483647);
		add_epoch(2147483648);
		add_epoch(SpanLo64 + 86399);
		add_epoch(SpanHi64 - 86399);
		add_epoch(1709251199);
		add_epoch(-62162121600);
		add_epoch(-12219292800);
		add_drain();
		for (int i = 0; i < RandomBeats; i++) begin
			if (i == RandomBeats / 2)
				add_drain();
			add_epoch(random_epoch());
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (epoch_backlog.size() != 0 || epoch_bus.valid)
			@(posedge clk);
		while (civil_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("Converted %0d timestamps: %0d out of range, %0d before 1970, %0d on Feb 29.",
			received, oor_seen, pre_epoch_seen, leap_days_seen);
		$display("Receiver held off 80 cycles once; sender drained twice; %0d errors.", errors);
		if (errors == 0)
			$display("PASS epoch_seconds_to_civil_datetime");
		else
			$display("FAIL epoch_seconds_to_civil_datetime");
		$finish;
	end

endmodule
